[design/tilted_column_scale_mapper_defines.svh]
`ifndef TILTED_COLUMN_SCALE_MAPPER_DEFINES_SVH
`define TILTED_COLUMN_SCALE_MAPPER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TCSM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tcsm_pkg.sv]
`default_nettype none

package tcsm_pkg;

    localparam int unsigned SCREEN_WIDTH_DEF  = 1024;
    localparam int unsigned SCREEN_HEIGHT_DEF = 768;

    localparam int unsigned ONE_Q16       = 65536;
    localparam int unsigned SCALE_MIN_Q16 = 6554;
    localparam int unsigned SCALE_MAX_Q16 = 327680;

    localparam int unsigned SLOPE_W  = 17;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned DCOL_W   = 14;
    localparam int unsigned SCALE_W  = 19;
    localparam int unsigned DISP_W   = 16;
    localparam int unsigned MAG_W    = 15;
    localparam int unsigned DIV_STEPS = 19;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_TILT_SLOPE    = 2'd0;
    localparam reg_index_t REG_SOURCE_WIDTH  = 2'd1;
    localparam reg_index_t REG_SOURCE_HEIGHT = 2'd2;

    localparam logic [SLOPE_W-1:0] TILT_SLOPE_RST    = 17'd0;
    localparam logic [SIZE_W-1:0]  SOURCE_WIDTH_RST  = 13'd64;
    localparam logic [SIZE_W-1:0]  SOURCE_HEIGHT_RST = 13'd64;

endpackage

`default_nettype wire

[design/tilted_column_scale_mapper.sv]
// Tilted column scale mapper: for each (source_column, target_row) item it returns the
// screen column, the echoed row, and the source row to fetch under a per-column vertical
// scale 1 + (x - width/2) * tilt_slope (Q3.16, clamped to [0.1, 5.0]), with copy_enable
// set when that row falls inside the image. Fully pipelined: one item per clock while
// the output is not stalled. The 19-stage restoring divider forms
// (row - offset) * 65536 / scale, one quotient bit per stage. A one-item skid register on
// the input keeps s_ready registered; while a result waits on m_ready the whole
// pipeline holds. Registers (APB, byte address 4*i): 0 tilt_slope, 1 source_width,
// 2 source_height; write them only while no item is in flight.
`default_nettype none
`include "tilted_column_scale_mapper_defines.svh"

module tilted_column_scale_mapper #(
    parameter int unsigned SCREEN_WIDTH  = tcsm_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = tcsm_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tcsm_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [tcsm_pkg::PDATA_W-1:0]        pwdata,
    output logic      [tcsm_pkg::PDATA_W-1:0]        prdata,
    output logic                                     pready,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [tcsm_pkg::COORD_W-1:0]        s_source_column,
    input  wire logic [tcsm_pkg::COORD_W-1:0]        s_target_row,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_copy_enable,
    output logic signed [tcsm_pkg::DCOL_W-1:0]       m_dest_column,
    output logic      [tcsm_pkg::COORD_W-1:0]        m_dest_row,
    output logic      [tcsm_pkg::COORD_W-1:0]        m_source_row
);

    localparam int unsigned SLOPE_W   = tcsm_pkg::SLOPE_W;
    localparam int unsigned SIZE_W    = tcsm_pkg::SIZE_W;
    localparam int unsigned COORD_W   = tcsm_pkg::COORD_W;
    localparam int unsigned DCOL_W    = tcsm_pkg::DCOL_W;
    localparam int unsigned SCALE_W   = tcsm_pkg::SCALE_W;
    localparam int unsigned DISP_W    = tcsm_pkg::DISP_W;
    localparam int unsigned MAG_W     = tcsm_pkg::MAG_W;
    localparam int unsigned DIV_STEPS = tcsm_pkg::DIV_STEPS;

    localparam logic [SIZE_W-1:0] SW_U = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0] SH_U = SIZE_W'(SCREEN_HEIGHT);

    // ---------------- configuration ----------------
    logic signed [SLOPE_W-1:0] tilt_slope_reg;
    logic [SIZE_W-1:0]         source_width_reg;
    logic [SIZE_W-1:0]         source_height_reg;
    logic                      cfg_write;
    tcsm_pkg::reg_index_t      cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_slope_reg    <= tcsm_pkg::TILT_SLOPE_RST;
            source_width_reg  <= tcsm_pkg::SOURCE_WIDTH_RST;
            source_height_reg <= tcsm_pkg::SOURCE_HEIGHT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                tcsm_pkg::REG_TILT_SLOPE:    tilt_slope_reg    <= pwdata[SLOPE_W-1:0];
                tcsm_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= pwdata[SIZE_W-1:0];
                tcsm_pkg::REG_SOURCE_HEIGHT: source_height_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            tcsm_pkg::REG_TILT_SLOPE:
                prdata = {{(32-SLOPE_W){tilt_slope_reg[SLOPE_W-1]}}, tilt_slope_reg};
            tcsm_pkg::REG_SOURCE_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, source_width_reg};
            tcsm_pkg::REG_SOURCE_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, source_height_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic ce;
    logic m_valid_reg;
    logic skid_full_reg, skid_full_next;
    logic [COORD_W-1:0] skid_col_reg, skid_row_reg;
    logic in_valid;
    logic [COORD_W-1:0] in_col, in_row;

    assign ce       = ~m_valid_reg | m_ready;
    assign s_ready  = ~skid_full_reg;
    assign in_valid = skid_full_reg | s_valid;
    assign in_col   = skid_full_reg ? skid_col_reg : s_source_column;
    assign in_row   = skid_full_reg ? skid_row_reg : s_target_row;

    always_comb begin
        if (ce) begin
            skid_full_next = 1'b0;
        end else begin
            skid_full_next = skid_full_reg | (s_valid & s_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (!ce && s_valid && s_ready) begin
            skid_col_reg <= s_source_column;
            skid_row_reg <= s_target_row;
        end
    end

    // ---------------- stage 1: column offset times slope, dest column ----------------
    logic signed [DCOL_W-1:0]         diff;
    logic signed [DCOL_W+SLOPE_W-1:0] s1_prod_next, s1_prod_reg;
    logic signed [DCOL_W:0]           dc_t, dc_half, dc_sum;
    logic signed [DCOL_W-1:0]         s1_dcol_next, s1_dcol_reg;
    logic [COORD_W-1:0]               s1_row_reg;
    logic                             s1_valid_reg;

    assign diff         = $signed({2'b0, in_col}) - $signed({2'b0, source_width_reg[SIZE_W-1:1]});
    assign s1_prod_next = diff * tilt_slope_reg;
    assign dc_t         = $signed({2'b0, SW_U}) - $signed({2'b0, source_width_reg});
    assign dc_half      = (dc_t + $signed({{DCOL_W{1'b0}}, dc_t[DCOL_W]})) >>> 1;
    assign dc_sum       = dc_half + $signed({3'b0, in_col});
    assign s1_dcol_next = dc_sum[DCOL_W-1:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_prod_reg <= s1_prod_next;
            s1_dcol_reg <= s1_dcol_next;
            s1_row_reg  <= in_row;
        end
    end

    // ---------------- stage 2: scale with clamp ----------------
    logic signed [DCOL_W+SLOPE_W+1:0] sc_sum;
    logic [SCALE_W-1:0]               s2_scale_next, s2_scale_reg;
    logic signed [DCOL_W-1:0]         s2_dcol_reg;
    logic [COORD_W-1:0]               s2_row_reg;
    logic                             s2_valid_reg;

    assign sc_sum = (DCOL_W+SLOPE_W+2)'(s1_prod_reg)
                  + $signed((DCOL_W+SLOPE_W+2)'(tcsm_pkg::ONE_Q16));

    always_comb begin
        if (sc_sum < $signed((DCOL_W+SLOPE_W+2)'(tcsm_pkg::SCALE_MIN_Q16))) begin
            s2_scale_next = SCALE_W'(tcsm_pkg::SCALE_MIN_Q16);
        end else if (sc_sum > $signed((DCOL_W+SLOPE_W+2)'(tcsm_pkg::SCALE_MAX_Q16))) begin
            s2_scale_next = SCALE_W'(tcsm_pkg::SCALE_MAX_Q16);
        end else begin
            s2_scale_next = sc_sum[SCALE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_scale_reg <= s2_scale_next;
            s2_dcol_reg  <= s1_dcol_reg;
            s2_row_reg   <= s1_row_reg;
        end
    end

    // ---------------- stage 3: scaled column height ----------------
    logic [SIZE_W+SCALE_W-1:0] hprod;
    logic [DISP_W-1:0]         s3_disp_next, s3_disp_reg;
    logic [SCALE_W-1:0]        s3_scale_reg;
    logic signed [DCOL_W-1:0]  s3_dcol_reg;
    logic [COORD_W-1:0]        s3_row_reg;
    logic                      s3_valid_reg;

    assign hprod        = source_height_reg * s2_scale_reg;
    assign s3_disp_next = hprod[SIZE_W+SCALE_W-1:16];

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_disp_reg  <= s3_disp_next;
            s3_scale_reg <= s2_scale_reg;
            s3_dcol_reg  <= s2_dcol_reg;
            s3_row_reg   <= s2_row_reg;
        end
    end

    // ---------------- stage 4: vertical offset ----------------
    logic signed [DISP_W+1:0] vo_t;
    logic signed [DISP_W+1:0] s4_voff_next, s4_voff_reg;
    logic [SCALE_W-1:0]       s4_scale_reg;
    logic signed [DCOL_W-1:0] s4_dcol_reg;
    logic [COORD_W-1:0]       s4_row_reg;
    logic                     s4_valid_reg;

    assign vo_t         = $signed({5'b0, SH_U}) - $signed({2'b0, s3_disp_reg});
    assign s4_voff_next = (vo_t + $signed({{(DISP_W+1){1'b0}}, vo_t[DISP_W+1]})) >>> 1;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_voff_reg  <= s4_voff_next;
            s4_scale_reg <= s3_scale_reg;
            s4_dcol_reg  <= s3_dcol_reg;
            s4_row_reg   <= s3_row_reg;
        end
    end

    // ---------------- stage 5 and divider: |num| * 65536 / scale ----------------
    logic [SCALE_W-1:0]       dv_rem_reg   [0:DIV_STEPS];
    logic [SCALE_W-1:0]       dv_rem_next  [0:DIV_STEPS];
    logic [SCALE_W-1:0]       dv_quot_reg  [0:DIV_STEPS];
    logic [SCALE_W-1:0]       dv_quot_next [0:DIV_STEPS];
    logic [2:0]               dv_lo_reg    [0:DIV_STEPS];
    logic [2:0]               dv_lo_next   [0:DIV_STEPS];
    logic [SCALE_W-1:0]       dv_scale_reg [0:DIV_STEPS];
    logic [SCALE_W-1:0]       dv_scale_next[0:DIV_STEPS];
    logic                     dv_neg_reg   [0:DIV_STEPS];
    logic                     dv_neg_next  [0:DIV_STEPS];
    logic signed [DCOL_W-1:0] dv_dcol_reg  [0:DIV_STEPS];
    logic signed [DCOL_W-1:0] dv_dcol_next [0:DIV_STEPS];
    logic [COORD_W-1:0]       dv_row_reg   [0:DIV_STEPS];
    logic [COORD_W-1:0]       dv_row_next  [0:DIV_STEPS];
    logic [DIV_STEPS:0]       dv_valid_reg, dv_valid_next;

    logic signed [DISP_W+1:0] num;
    logic signed [DISP_W+1:0] num_abs;

    assign num     = $signed({6'b0, s4_row_reg}) - s4_voff_reg;
    assign num_abs = num[DISP_W+1] ? -num : num;

    assign dv_rem_next[0]   = {{(SCALE_W-MAG_W+3){1'b0}}, num_abs[MAG_W-1:3]};
    assign dv_lo_next[0]    = num_abs[2:0];
    assign dv_quot_next[0]  = '0;
    assign dv_scale_next[0] = s4_scale_reg;
    assign dv_neg_next[0]   = num[DISP_W+1];
    assign dv_dcol_next[0]  = s4_dcol_reg;
    assign dv_row_next[0]   = s4_row_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic             nb;
        logic [SCALE_W:0] trial;
        logic [SCALE_W:0] diffd;
        logic             ge;

        if (k < 3) begin : g_bit
            assign nb = dv_lo_reg[k][2-k];
        end else begin : g_zero
            assign nb = 1'b0;
        end

        assign trial = {dv_rem_reg[k], nb};
        assign diffd = trial - {1'b0, dv_scale_reg[k]};
        assign ge    = ~diffd[SCALE_W];

        assign dv_rem_next[k+1]   = ge ? diffd[SCALE_W-1:0] : trial[SCALE_W-1:0];
        assign dv_quot_next[k+1]  = {dv_quot_reg[k][SCALE_W-2:0], ge};
        assign dv_lo_next[k+1]    = dv_lo_reg[k];
        assign dv_scale_next[k+1] = dv_scale_reg[k];
        assign dv_neg_next[k+1]   = dv_neg_reg[k];
        assign dv_dcol_next[k+1]  = dv_dcol_reg[k];
        assign dv_row_next[k+1]   = dv_row_reg[k];
    end

    for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_dv_regs
        always_ff @(posedge aclk) begin
            if (ce) begin
                dv_rem_reg[k]   <= dv_rem_next[k];
                dv_quot_reg[k]  <= dv_quot_next[k];
                dv_lo_reg[k]    <= dv_lo_next[k];
                dv_scale_reg[k] <= dv_scale_next[k];
                dv_neg_reg[k]   <= dv_neg_next[k];
                dv_dcol_reg[k]  <= dv_dcol_next[k];
                dv_row_reg[k]   <= dv_row_next[k];
            end
        end
    end

    assign dv_valid_next = {dv_valid_reg[DIV_STEPS-1:0], s4_valid_reg};

    // ---------------- output stage ----------------
    logic [SCALE_W-1:0]       q;
    logic                     m_copy_enable_next, m_copy_enable_reg;
    logic [COORD_W-1:0]       m_source_row_next, m_source_row_reg;
    logic signed [DCOL_W-1:0] m_dest_column_reg;
    logic [COORD_W-1:0]       m_dest_row_reg;

    assign q = dv_quot_reg[DIV_STEPS];

    always_comb begin
        if (dv_neg_reg[DIV_STEPS]) begin
            m_copy_enable_next = (q == '0) && (source_height_reg != '0);
        end else begin
            m_copy_enable_next = q < {{(SCALE_W-SIZE_W){1'b0}}, source_height_reg};
        end
        m_source_row_next = m_copy_enable_next ? q[COORD_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_copy_enable_reg <= m_copy_enable_next;
            m_source_row_reg  <= m_source_row_next;
            m_dest_column_reg <= dv_dcol_reg[DIV_STEPS];
            m_dest_row_reg    <= dv_row_reg[DIV_STEPS];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_copy_enable = m_copy_enable_reg;
    assign m_source_row  = m_source_row_reg;
    assign m_dest_column = m_dest_column_reg;
    assign m_dest_row    = m_dest_row_reg;

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            skid_full_reg <= skid_full_next;
            if (ce) begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                dv_valid_reg <= dv_valid_next;
                m_valid_reg  <= dv_valid_reg[DIV_STEPS];
            end
        end
    end

    // ---------------- assertions ----------------
    `TCSM_ASSERT(a_scale_range, s2_valid_reg, (s2_scale_reg >= SCALE_W'(tcsm_pkg::SCALE_MIN_Q16)) && (s2_scale_reg <= SCALE_W'(tcsm_pkg::SCALE_MAX_Q16)), "scale outside clamp range")
    `TCSM_ASSERT(a_div_rem_bound, dv_valid_reg[DIV_STEPS], dv_rem_reg[DIV_STEPS] < dv_scale_reg[DIV_STEPS], "divider remainder not below divisor")
    `TCSM_ASSERT(a_copy_row_inside, m_valid_reg && m_copy_enable_reg, {1'b0, m_source_row_reg} < source_height_reg, "copied row outside image")
    `TCSM_ASSERT_NEXT(a_skid_hold, skid_full_reg && !ce, skid_full_reg && $stable(skid_row_reg) && $stable(skid_col_reg), "skid item lost during stall")
    `TCSM_ASSERT_NEXT(a_stall_hold, !ce, $stable(dv_valid_reg), "pipeline moved during stall")

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam longint Q_ONE     = tcsm_pkg::ONE_Q16;
    localparam longint Q_MIN     = tcsm_pkg::SCALE_MIN_Q16;
    localparam longint Q_MAX     = tcsm_pkg::SCALE_MAX_Q16;
    localparam longint SCR_W     = tcsm_pkg::SCREEN_WIDTH_DEF;
    localparam longint SCR_H     = tcsm_pkg::SCREEN_HEIGHT_DEF;
    localparam int     MAX_SHOWN = 40;
    localparam int     HOLD_LEN  = 300;

    typedef struct {
        logic                          copy;
        logic [tcsm_pkg::DCOL_W-1:0]   dcol;
        logic [tcsm_pkg::COORD_W-1:0]  drow;
        logic [tcsm_pkg::COORD_W-1:0]  srow;
    } mapping_t;

    class scale_map_scoreboard;
        longint   slope;
        longint   width;
        longint   height;
        mapping_t pending_maps[$];
        int       errors;
        int       items_in;
        int       results;
        int       copies_seen;

        function new();
            slope  = 0;
            width  = 64;
            height = 64;
        endfunction

        function void write_reg(tcsm_pkg::reg_index_t idx,
                                logic [tcsm_pkg::PDATA_W-1:0] data);
            case (idx)
                tcsm_pkg::REG_TILT_SLOPE:
                    slope  = longint'($signed(data[tcsm_pkg::SLOPE_W-1:0]));
                tcsm_pkg::REG_SOURCE_WIDTH:
                    width  = longint'(data[tcsm_pkg::SIZE_W-1:0]);
                tcsm_pkg::REG_SOURCE_HEIGHT:
                    height = longint'(data[tcsm_pkg::SIZE_W-1:0]);
                default: ;
            endcase
        endfunction

        // per-column scale, centered height, then row back-projection
        function void note_item(logic [tcsm_pkg::COORD_W-1:0] col,
                                logic [tcsm_pkg::COORD_W-1:0] row);
            longint   c;
            longint   r;
            longint   scale;
            longint   disp_h;
            longint   voff;
            longint   src;
            longint   dcol;
            mapping_t e;
            c = longint'(col);
            r = longint'(row);
            scale = Q_ONE + (c - width / 2) * slope;
            if (scale < Q_MIN) scale = Q_MIN;
            if (scale > Q_MAX) scale = Q_MAX;
            disp_h = (height * scale) >>> 16;
            voff   = (SCR_H - disp_h) / 2;
            src    = ((r - voff) * Q_ONE) / scale;
            dcol   = (SCR_W - width) / 2 + c;
            e.copy = (src >= 0) && (src < height);
            e.dcol = dcol[tcsm_pkg::DCOL_W-1:0];
            e.drow = row;
            e.srow = e.copy ? src[tcsm_pkg::COORD_W-1:0] : '0;
            pending_maps.push_back(e);
            items_in++;
        endfunction

        function void mismatch(string field, logic [15:0] exp_v, logic [15:0] act_v);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
        endfunction

        function void check_result(logic ce, logic [tcsm_pkg::DCOL_W-1:0] dc,
                                   logic [tcsm_pkg::COORD_W-1:0] dr,
                                   logic [tcsm_pkg::COORD_W-1:0] sr);
            mapping_t e;
            if (pending_maps.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: unexpected result, expected none, got %b %h %h %h",
                             $time, ce, dc, dr, sr);
                return;
            end
            e = pending_maps.pop_front();
            results++;
            if (e.copy) copies_seen++;
            if (ce !== e.copy) mismatch("copy_enable", 16'(e.copy), 16'(ce));
            if (dc !== e.dcol) mismatch("dest_column", 16'(e.dcol), 16'(dc));
            if (dr !== e.drow) mismatch("dest_row", 16'(e.drow), 16'(dr));
            if (sr !== e.srow) mismatch("source_row", 16'(e.srow), 16'(sr));
        endfunction

        function int pending();
            return pending_maps.size();
        endfunction
    endclass

    logic                                aclk    = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [tcsm_pkg::PADDR_W-1:0]        paddr   = '0;
    logic [tcsm_pkg::PDATA_W-1:0]        pwdata  = '0;
    logic [tcsm_pkg::PDATA_W-1:0]        prdata;
    logic                                pready;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [tcsm_pkg::COORD_W-1:0]        s_source_column = '0;
    logic [tcsm_pkg::COORD_W-1:0]        s_target_row    = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic                                m_copy_enable;
    logic signed [tcsm_pkg::DCOL_W-1:0]  m_dest_column;
    logic [tcsm_pkg::COORD_W-1:0]        m_dest_row;
    logic [tcsm_pkg::COORD_W-1:0]        m_source_row;

    scale_map_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int config_count   = 1;

    tilted_column_scale_mapper u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_column (s_source_column),
        .s_target_row    (s_target_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_copy_enable   (m_copy_enable),
        .m_dest_column   (m_dest_column),
        .m_dest_row      (m_dest_row),
        .m_source_row    (m_source_row)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_item(s_source_column, s_target_row);
            if (m_valid && m_ready)
                sb.check_result(m_copy_enable, m_dest_column, m_dest_row, m_source_row);
        end
    end

    // output side: random stalls plus an occasional long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_len > 0) begin
            m_ready  <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic [tcsm_pkg::COORD_W-1:0] col,
                             logic [tcsm_pkg::COORD_W-1:0] row);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_source_column <= col;
        s_target_row    <= row;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic apb_write(tcsm_pkg::reg_index_t idx, logic [tcsm_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tcsm_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(longint slope, longint w, longint h, bit junk);
        logic [tcsm_pkg::PDATA_W-1:0] d;
        pause_for_results();
        d = junk ? tcsm_pkg::PDATA_W'($urandom()) : '0;
        d[tcsm_pkg::SLOPE_W-1:0] = slope[tcsm_pkg::SLOPE_W-1:0];
        apb_write(tcsm_pkg::REG_TILT_SLOPE, d);
        d = junk ? tcsm_pkg::PDATA_W'($urandom()) : '0;
        d[tcsm_pkg::SIZE_W-1:0] = w[tcsm_pkg::SIZE_W-1:0];
        apb_write(tcsm_pkg::REG_SOURCE_WIDTH, d);
        d = junk ? tcsm_pkg::PDATA_W'($urandom()) : '0;
        d[tcsm_pkg::SIZE_W-1:0] = h[tcsm_pkg::SIZE_W-1:0];
        apb_write(tcsm_pkg::REG_SOURCE_HEIGHT, d);
        config_count++;
    endtask

    task automatic random_config();
        longint w;
        longint h;
        longint s;
        longint span;
        case ($urandom_range(0, 7))
            0:       w = 1;
            1:       w = 4096;
            2:       w = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
            default: w = $urandom_range(2, 1024);
        endcase
        case ($urandom_range(0, 7))
            0:       h = 1;
            1:       h = 4096;
            2:       h = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
            default: h = $urandom_range(2, 768);
        endcase
        span = 131072 / (w + 1) + 1;
        case ($urandom_range(0, 5))
            0:       s = -65536;
            1:       s = 65535;
            2:       s = longint'($urandom_range(0, 131071)) - 65536;
            default: s = longint'($urandom_range(0, 2 * span)) - span;
        endcase
        apply_config(s, w, h, 1'b1);
    endtask

    // mostly in-image columns and on-screen rows, some full-range noise
    task automatic run_random(int n);
        longint col_max;
        logic [tcsm_pkg::COORD_W-1:0] col;
        logic [tcsm_pkg::COORD_W-1:0] row;
        col_max = (sb.width == 0) ? 0 : ((sb.width > 4096) ? 4095 : sb.width - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                col = tcsm_pkg::COORD_W'($urandom());
                row = tcsm_pkg::COORD_W'($urandom());
            end else begin
                col = tcsm_pkg::COORD_W'($urandom_range(0, int'(col_max)));
                row = tcsm_pkg::COORD_W'($urandom_range(0, int'(SCR_H) - 1));
            end
            send_item(col, row);
        end
    endtask

    task automatic run_directed();
        send_item(0, 0);
        send_item(4095, 4095);
        send_item(63, 767);
        send_item(32, 384);
        send_item(4095, 0);
        send_item(0, 4095);
        apply_config(65535, 64, 64, 1'b0);
        send_item(33, 319);     // quotient just below zero truncates to row 0
        send_item(33, 320);
        send_item(0, 0);        // scale clamps low
        send_item(63, 500);     // scale clamps high
        apply_config(-65536, 8191, 8191, 1'b0);
        send_item(4095, 4095);
        send_item(0, 0);
        send_item(2048, 100);
        apply_config(0, 4096, 0, 1'b0);     // zero height
        send_item(10, 384);
        send_item(4095, 0);
        apply_config(-300, 0, 4096, 1'b0);  // zero width
        send_item(0, 0);
        send_item(4095, 767);
        send_item(1, 2000);
        apply_config(200, 1, 1, 1'b1);
        send_item(0, 384);
        send_item(0, 383);
        send_item(4095, 4095);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 4) begin
                // fill the pipe against a held output, then drain before going on
                hold_len = HOLD_LEN;
                run_random(120);
                pause_for_results();
                run_random(120);
            end else begin
                run_random(240);
            end
        end

        pause_for_results();
        repeat (40) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d items never produced a result", $time, sb.pending());
        end

        $display("Run covered %0d items (%0d copied) over %0d register settings,",
                 sb.items_in, sb.copies_seen, config_count);
        $display("with idle and stall phases and one long output hold; %0d errors.",
                 sb.errors);
        if (sb.errors == 0 && sb.results == sb.items_in) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
